// ===== design/api_frame_receiver_macros.svh =====
// Assertion macros for the API frame receiver.
`ifndef API_FRAME_RECEIVER_MACROS_SVH
`define API_FRAME_RECEIVER_MACROS_SVH

// Plain property, checked on clk_i outside reset.
`define AFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define AFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/afr_pkg.sv =====
// Types, constants and helpers shared by the API frame receiver modules.
`default_nettype none

package afr_pkg;

  localparam int unsigned PAYLOAD_DEPTH = 128;
  localparam int unsigned IDX_W = $clog2(PAYLOAD_DEPTH);
  // each bank spans a full power-of-two index range so {bank, index} addresses stay in range
  localparam int unsigned MEM_DEPTH = 2 * (1 << IDX_W);
  localparam int unsigned MEM_AW = $clog2(MEM_DEPTH);
  localparam logic [8:0] DEPTH_C = 9'(PAYLOAD_DEPTH);

  localparam logic [7:0] START_MARK = 8'h7E;
  localparam logic [7:0] API_RX64 = 8'h80;
  localparam logic [7:0] API_RX16 = 8'h81;
  localparam logic [7:0] API_TXSTAT = 8'h89;
  localparam logic [7:0] SUM_OK = 8'hFF;

  localparam logic [7:0] HDR_RX64 = 8'd12;
  localparam logic [7:0] HDR_RX16 = 8'd6;
  localparam logic [7:0] CNT_RX64 = 8'd11;
  localparam logic [7:0] CNT_RX16 = 8'd5;
  localparam logic [7:0] LEN_BYTES = 8'd2;

  typedef enum logic [1:0] {
    REQ_BYTE    = 2'd0,
    REQ_READ    = 2'd1,
    REQ_RELEASE = 2'd2,
    REQ_TX_PEND = 2'd3
  } req_e;

  typedef enum logic [7:0] {
    ST_WAIT = 8'b0000_0001,
    ST_LEN  = 8'b0000_0010,
    ST_API  = 8'b0000_0100,
    ST_RX64 = 8'b0000_1000,
    ST_RX16 = 8'b0001_0000,
    ST_SKIP = 8'b0010_0000,
    ST_TXS  = 8'b0100_0000,
    ST_SUM  = 8'b1000_0000
  } parse_state_e;

  typedef struct packed {
    logic              we;
    logic [MEM_AW-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [MEM_AW-1:0] raddr;
  } afr_mem_cmd_t;

  typedef struct packed {
    logic [7:0]  payload_length;
    logic [7:0]  rx_options;
    logic [7:0]  signal_strength;
    logic [63:0] source_address;
    logic        short_address;
    logic        clear_to_send;
    logic        copy_full;
    logic        captured;
    logic        frame_good;
    logic        frame_end;
    logic        index_ok;
    logic [7:0]  data_byte;
  } afr_result_t;

  // Payload bytes in a receive frame: length less header, capped at buffer depth.
  function automatic logic [7:0] payload_count(input logic [7:0] len, input logic [7:0] hdr);
    logic [8:0] n;
    n = (len > hdr) ? {1'b0, len - hdr} : 9'd0;
    if (n > DEPTH_C) n = DEPTH_C;
    return n[7:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/afr_payload_ram.sv =====
// Two-bank payload buffer: one write port, one registered read port.
`default_nettype none

module afr_payload_ram
  import afr_pkg::*;
(
  input  wire logic         clk_i,
  input  wire afr_mem_cmd_t cmd_i,
  output logic [7:0]        rdata_o
);

  logic [7:0] mem [MEM_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      mem[cmd_i.waddr] <= cmd_i.wdata;
    end
    if (cmd_i.re) begin
      rdata_q <= mem[cmd_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/afr_parser.sv =====
// Frame parser: delimiter/length/API decode, checksum, header capture and held copy.
`default_nettype none

module afr_parser
  import afr_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         take_i,
  input  wire logic [1:0]   req_type_i,
  input  wire logic [7:0]   byte_value_i,
  input  wire logic [6:0]   read_index_i,
  output afr_mem_cmd_t      mem_cmd_o,
  output afr_result_t       result_o
);

  parse_state_e state_q, state_d;
  logic [7:0]  pos_q, pos_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  kind_q, kind_d;
  logic [7:0]  sum_q, sum_d;
  logic [63:0] waddr_q, waddr_d;
  logic [7:0]  wrssi_q, wrssi_d;
  logic [7:0]  wopts_q, wopts_d;
  logic        wshort_q, wshort_d;
  logic [7:0]  wcnt_q, wcnt_d;
  logic        bank_q, bank_d;
  logic [63:0] haddr_q, haddr_d;
  logic [7:0]  hrssi_q, hrssi_d;
  logic [7:0]  hopts_q, hopts_d;
  logic        hshort_q, hshort_d;
  logic [7:0]  hcnt_q, hcnt_d;
  logic        flag_q, flag_d;
  logic        tx_q, tx_d;

  logic [7:0] sum_add;
  logic [7:0] pos_inc;
  logic [7:0] hdr;
  logic [7:0] store_idx;
  logic [8:0] idx_ext;
  logic       is_rx;
  logic       frame_end, frame_good, captured, index_ok;
  req_e       req;

  assign req     = req_e'(req_type_i);
  assign sum_add = sum_q + byte_value_i;
  assign pos_inc = pos_q + 8'd1;
  assign hdr     = (state_q == ST_RX64) ? HDR_RX64 : HDR_RX16;
  assign store_idx = pos_inc - hdr;
  assign idx_ext = {2'b00, read_index_i};
  assign is_rx   = (kind_q == API_RX64) || (kind_q == API_RX16);

  always_comb begin
    state_d  = state_q;
    pos_d    = pos_q;
    len_d    = len_q;
    kind_d   = kind_q;
    sum_d    = sum_q;
    waddr_d  = waddr_q;
    wrssi_d  = wrssi_q;
    wopts_d  = wopts_q;
    wshort_d = wshort_q;
    wcnt_d   = wcnt_q;
    bank_d   = bank_q;
    haddr_d  = haddr_q;
    hrssi_d  = hrssi_q;
    hopts_d  = hopts_q;
    hshort_d = hshort_q;
    hcnt_d   = hcnt_q;
    flag_d   = flag_q;
    tx_d     = tx_q;
    frame_end  = 1'b0;
    frame_good = 1'b0;
    captured   = 1'b0;
    index_ok   = 1'b0;
    mem_cmd_o.we    = 1'b0;
    mem_cmd_o.waddr = {~bank_q, store_idx[IDX_W-1:0]};
    mem_cmd_o.wdata = byte_value_i;
    mem_cmd_o.re    = 1'b0;
    mem_cmd_o.raddr = {bank_q, idx_ext[IDX_W-1:0]};

    case (req)
      REQ_BYTE: begin
        case (state_q)
          ST_WAIT: begin
            if (byte_value_i == START_MARK) begin
              pos_d   = '0;
              sum_d   = '0;
              state_d = ST_LEN;
            end
          end
          ST_LEN: begin
            pos_d = pos_inc;
            if (pos_inc == LEN_BYTES) begin
              len_d   = byte_value_i;
              pos_d   = '0;
              state_d = ST_API;
            end
          end
          ST_API: begin
            pos_d  = 8'd1;
            kind_d = byte_value_i;
            sum_d  = sum_add;
            if (byte_value_i == API_RX64 || byte_value_i == API_RX16) begin
              waddr_d  = '0;
              wrssi_d  = '0;
              wopts_d  = '0;
              wshort_d = (byte_value_i == API_RX16);
              wcnt_d   = payload_count(len_q,
                           (byte_value_i == API_RX64) ? CNT_RX64 : CNT_RX16);
              state_d  = (byte_value_i == API_RX64) ? ST_RX64 : ST_RX16;
            end else if (byte_value_i == API_TXSTAT) begin
              state_d = ST_TXS;
            end else begin
              state_d = ST_SKIP;
            end
            if (len_q <= 8'd1) state_d = ST_SUM;
          end
          ST_RX64, ST_RX16: begin
            pos_d = pos_inc;
            sum_d = sum_add;
            if (pos_inc <= hdr - 8'd3) begin
              waddr_d = {waddr_q[55:0], byte_value_i};
            end else if (pos_inc == hdr - 8'd2) begin
              wrssi_d = byte_value_i;
            end else if (pos_inc == hdr - 8'd1) begin
              wopts_d = byte_value_i;
            end else if ({1'b0, store_idx} < DEPTH_C) begin
              mem_cmd_o.we = 1'b1;
            end
            if (pos_inc >= len_q) state_d = ST_SUM;
          end
          ST_TXS: begin
            tx_d  = 1'b1;
            pos_d = pos_inc;
            sum_d = sum_add;
            if (pos_inc >= len_q) state_d = ST_SUM;
          end
          ST_SKIP: begin
            pos_d = pos_inc;
            sum_d = sum_add;
            if (pos_inc >= len_q) state_d = ST_SUM;
          end
          ST_SUM: begin
            sum_d     = sum_add;
            frame_end = 1'b1;
            state_d   = ST_WAIT;
            if (sum_add == SUM_OK) begin
              frame_good = 1'b1;
              if (is_rx && !flag_q) begin
                haddr_d  = waddr_q;
                hrssi_d  = wrssi_q;
                hopts_d  = wopts_q;
                hshort_d = wshort_q;
                hcnt_d   = wcnt_q;
                bank_d   = ~bank_q;
                flag_d   = 1'b1;
                captured = 1'b1;
              end
            end
          end
          default: begin
            sum_d     = sum_add;
            frame_end = 1'b1;
            state_d   = ST_WAIT;
          end
        endcase
      end
      REQ_READ: begin
        mem_cmd_o.re = 1'b1;
        index_ok = flag_q && (idx_ext < {1'b0, hcnt_q}) && (idx_ext < DEPTH_C);
      end
      REQ_RELEASE: flag_d = 1'b0;
      REQ_TX_PEND: tx_d = 1'b0;
      default: ;
    endcase

    if (!take_i) begin
      mem_cmd_o.we = 1'b0;
      mem_cmd_o.re = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_WAIT;
      pos_q    <= '0;
      len_q    <= '0;
      kind_q   <= '0;
      sum_q    <= '0;
      waddr_q  <= '0;
      wrssi_q  <= '0;
      wopts_q  <= '0;
      wshort_q <= 1'b0;
      wcnt_q   <= '0;
      bank_q   <= 1'b0;
      haddr_q  <= '0;
      hrssi_q  <= '0;
      hopts_q  <= '0;
      hshort_q <= 1'b0;
      hcnt_q   <= '0;
      flag_q   <= 1'b0;
      tx_q     <= 1'b1;
    end else if (take_i) begin
      state_q  <= state_d;
      pos_q    <= pos_d;
      len_q    <= len_d;
      kind_q   <= kind_d;
      sum_q    <= sum_d;
      waddr_q  <= waddr_d;
      wrssi_q  <= wrssi_d;
      wopts_q  <= wopts_d;
      wshort_q <= wshort_d;
      wcnt_q   <= wcnt_d;
      bank_q   <= bank_d;
      haddr_q  <= haddr_d;
      hrssi_q  <= hrssi_d;
      hopts_q  <= hopts_d;
      hshort_q <= hshort_d;
      hcnt_q   <= hcnt_d;
      flag_q   <= flag_d;
      tx_q     <= tx_d;
    end
  end

  always_comb begin
    result_o.payload_length  = hcnt_d;
    result_o.rx_options      = hopts_d;
    result_o.signal_strength = hrssi_d;
    result_o.source_address  = haddr_d;
    result_o.short_address   = hshort_d;
    result_o.clear_to_send   = tx_d;
    result_o.copy_full       = flag_d;
    result_o.captured        = captured;
    result_o.frame_good      = frame_good;
    result_o.frame_end       = frame_end;
    result_o.index_ok        = index_ok;
    result_o.data_byte       = '0;
  end

endmodule

`default_nettype wire

// ===== design/api_frame_receiver.sv =====
// API frame receiver top level: parser, payload buffer and output stages.
// The result is registered in the read stage and then in the output stage before the master side sees it.
// Throughput: one item per cycle unless the master stalls; the payload buffer takes at most one write or read per item.
// A payload read is issued at the input transfer; its registered data joins the result on entering the output stage.
// Reset: parser waits for a start delimiter, nothing held, clear-to-send set, outputs empty.
// The payload buffer is not cleared; only bytes of a held frame are ever reported.
`default_nettype none
`include "api_frame_receiver_macros.svh"

module api_frame_receiver
  import afr_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [15:0]  s_axis_tdata_i,   // byte_value, read_index, pad
  input  wire logic [1:0]   s_axis_tuser_i,   // req_type
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // data_byte, index_ok, frame_good, captured, copy_full, clear_to_send,
  // source_address, signal_strength, rx_options, payload_length, pad
  output logic [103:0]      m_axis_tdata_o,
  output logic              m_axis_tuser_o,   // short_address
  output logic              m_axis_tlast_o    // frame_end
);

  afr_mem_cmd_t mem_cmd;
  afr_result_t  step_res;
  logic [7:0]   rdata;
  logic         accept;
  logic         out_free;

  logic         s1_valid_q, s1_valid_d;
  afr_result_t  s1_res_q;
  logic         out_valid_q, out_valid_d;
  afr_result_t  out_res_q, out_res_d;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !s1_valid_q || out_free;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  afr_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (accept),
    .req_type_i   (s_axis_tuser_i),
    .byte_value_i (s_axis_tdata_i[7:0]),
    .read_index_i (s_axis_tdata_i[14:8]),
    .mem_cmd_o    (mem_cmd),
    .result_o     (step_res)
  );

  afr_payload_ram u_ram (
    .clk_i   (clk_i),
    .cmd_i   (mem_cmd),
    .rdata_o (rdata)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (out_free) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_free ? s1_valid_q : out_valid_q;
    out_res_d = s1_res_q;
    out_res_d.data_byte = s1_res_q.index_ok ? rdata : 8'h00;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_res_q <= step_res;
    end
    if (out_free && s1_valid_q) begin
      out_res_q <= out_res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_res_q.short_address;
  assign m_axis_tlast_o  = out_res_q.frame_end;
  assign m_axis_tdata_o  = {3'b000,
                            out_res_q.payload_length,
                            out_res_q.rx_options,
                            out_res_q.signal_strength,
                            out_res_q.source_address,
                            out_res_q.clear_to_send,
                            out_res_q.copy_full,
                            out_res_q.captured,
                            out_res_q.frame_good,
                            out_res_q.index_ok,
                            out_res_q.data_byte};

  `AFR_ASSERT(a_no_overrun, (s1_valid_q && out_valid_q && !m_axis_tready_i) |-> !s_axis_tready_o, "input taken while both stages are blocked")
  `AFR_ASSERT_NEXT(a_accept_fills_s1, accept, s1_valid_q, "accepted transfer did not reach the read stage")
  `AFR_ASSERT(a_capture_holds, (out_valid_q && out_res_q.captured) |-> (out_res_q.copy_full && out_res_q.frame_good && out_res_q.frame_end), "capture reported without a good held frame")
  `AFR_ASSERT(a_read_only_when_held, (out_valid_q && out_res_q.index_ok) |-> (out_res_q.copy_full && !out_res_q.frame_end), "payload read reported with nothing held")

endmodule

`default_nettype wire
